### rtl/second_chance_page_victim_defines.svh
// Assertion macros used by the page victim RTL
`ifndef SECOND_CHANCE_PAGE_VICTIM_DEFINES_SVH
`define SECOND_CHANCE_PAGE_VICTIM_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define SCPV_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define SCPV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/scpv_pkg.sv
package scpv_pkg;

    // Request kind carried with each input item
    typedef logic t_mode;

    localparam t_mode MODE_INSERT = 1'b0;
    localparam t_mode MODE_VICTIM = 1'b1;

endpackage

### rtl/scpv_req_if.sv
interface scpv_req_if #(
    parameter int PAGE_BITS = 20
) ();
    import scpv_pkg::*;

    logic                 valid;
    logic                 ready;
    t_mode                mode;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output mode, output page_number, input ready);
    modport sink   (input valid, input mode, input page_number, output ready);
endinterface

### rtl/scpv_rsp_if.sv
interface scpv_rsp_if #(
    parameter int PAGE_BITS = 20
) ();
    logic                 valid;
    logic                 ready;
    logic                 victim_found;
    logic [PAGE_BITS-1:0] victim_page;
    logic                 list_full;

    modport source (output valid, output victim_found, output victim_page,
                    output list_full, input ready);
    modport sink   (input valid, input victim_found, input victim_page,
                    input list_full, output ready);
endinterface

### rtl/second_chance_page_victim.sv
// Channel  Dir  Payload                                  Accepted when
// i_req    in   mode, page_number                        valid && ready
// o_rsp    out  victim_found, victim_page, list_full     valid && ready
//
// Insert, or a victim request that removes nothing: after acceptance, EXEC, then DONE
// loads the output register. Victim: EXEC, then SHIFT captures the victim page and
// compacts the page memory one entry per cycle (read i+1, write i), then DONE.
// A new item is accepted from the cycle after the result enters the output register.
// Reset empties the list and clears all visited marks at once.
// The output register holds a result until taken; meanwhile the block keeps working but waits in DONE until it is free.
`include "second_chance_page_victim_defines.svh"

module second_chance_page_victim #(
    parameter int NUM_FRAMES = 16,
    parameter int PAGE_BITS  = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scpv_req_if.sink  i_req,
    scpv_rsp_if.source o_rsp
);
    import scpv_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Control state
    logic [1:0]            r_state,     n_state;
    logic [CW-1:0]         r_count,     n_count;
    logic [NUM_FRAMES-1:0] r_marks,     n_marks;
    logic                  r_out_valid, n_out_valid;

    // Working and payload state
    t_mode                 r_mode,      n_mode;
    logic [PAGE_BITS-1:0]  r_page,      n_page;
    logic                  r_first,     n_first;
    logic [IW-1:0]         r_rd_addr,   n_rd_addr;
    logic [CW-1:0]         r_rd_next,   n_rd_next;
    logic [CW-1:0]         r_end,       n_end;
    logic                  r_res_found, n_res_found;
    logic [PAGE_BITS-1:0]  r_res_page,  n_res_page;
    logic                  r_res_full,  n_res_full;
    logic                  r_out_found, n_out_found;
    logic [PAGE_BITS-1:0]  r_out_page,  n_out_page;
    logic                  r_out_full,  n_out_full;

    // Page memory access
    logic                  s_wr_en;
    logic [IW-1:0]         s_wr_addr;
    logic [PAGE_BITS-1:0]  s_wr_data;
    logic                  s_rd_en;
    logic [IW-1:0]         s_rd_addr;
    logic [PAGE_BITS-1:0]  s_rd_data;

    // Victim search
    logic [NUM_FRAMES-1:0] s_live;
    logic [NUM_FRAMES-1:0] s_marks_down;
    logic [NUM_FRAMES-1:0] s_marks_kept;
    logic                  s_vic_found;
    logic [IW-1:0]         s_vic_idx;

    scpv_page_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (PAGE_BITS)
    ) u_page_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (s_wr_data),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    // Find the oldest live entry without a mark; build the compacted marks
    always_comb begin
        s_vic_found  = 1'b0;
        s_vic_idx    = '0;
        s_marks_down = r_marks >> 1;
        for (int j = 0; j < NUM_FRAMES; j++) begin
            s_live[j] = (CW'(j) < r_count);
        end
        for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
            if (s_live[j] && !r_marks[j]) begin
                s_vic_found = 1'b1;
                s_vic_idx   = IW'(j);
            end
        end
        // Entries older than the victim were all marked and are now clear
        for (int j = 0; j < NUM_FRAMES; j++) begin
            s_marks_kept[j] = (IW'(j) >= s_vic_idx) ? s_marks_down[j] : 1'b0;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_marks     = r_marks;
        n_mode      = r_mode;
        n_page      = r_page;
        n_first     = r_first;
        n_rd_addr   = r_rd_addr;
        n_rd_next   = r_rd_next;
        n_end       = r_end;
        n_res_found = r_res_found;
        n_res_page  = r_res_page;
        n_res_full  = r_res_full;
        n_out_found = r_out_found;
        n_out_page  = r_out_page;
        n_out_full  = r_out_full;
        n_out_valid = r_out_valid && !o_rsp.ready;
        s_wr_en     = 1'b0;
        s_wr_addr   = '0;
        s_wr_data   = r_page;
        s_rd_en     = 1'b0;
        s_rd_addr   = '0;

        case (r_state)
            ST_IDLE: begin
                // Take the next item
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_page  = i_req.page_number;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_found = 1'b0;
                n_res_page  = '0;
                n_res_full  = 1'b0;
                n_state     = ST_DONE;
                if (r_mode == MODE_INSERT) begin
                    // Append at the newest end, or drop when full
                    if (r_count == CW'(NUM_FRAMES)) begin
                        n_res_full = 1'b1;
                    end else begin
                        s_wr_en                    = 1'b1;
                        s_wr_addr                  = r_count[IW-1:0];
                        s_wr_data                  = r_page;
                        n_marks[r_count[IW-1:0]]   = 1'b1;
                        n_count                    = r_count + CW'(1);
                    end
                end else if (!s_vic_found) begin
                    // Every entry got its second chance
                    n_marks = '0;
                end else begin
                    // Remove the victim and start reading from its slot
                    n_res_found = 1'b1;
                    n_marks     = s_marks_kept;
                    n_count     = r_count - CW'(1);
                    s_rd_en     = 1'b1;
                    s_rd_addr   = s_vic_idx;
                    n_rd_addr   = s_vic_idx;
                    n_rd_next   = CW'(s_vic_idx) + CW'(1);
                    n_end       = r_count;
                    n_first     = 1'b1;
                    n_state     = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // Capture the victim page, then move each newer page down one slot
                if (r_first) begin
                    n_res_page = s_rd_data;
                    n_first    = 1'b0;
                end else begin
                    s_wr_en   = 1'b1;
                    s_wr_addr = r_rd_addr - IW'(1);
                    s_wr_data = s_rd_data;
                end
                if (r_rd_next < r_end) begin
                    s_rd_en   = 1'b1;
                    s_rd_addr = r_rd_next[IW-1:0];
                    n_rd_addr = r_rd_next[IW-1:0];
                    n_rd_next = r_rd_next + CW'(1);
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_page  = r_res_page;
                    n_out_full  = r_res_full;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_marks     <= n_marks;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_page      <= n_page;
        r_first     <= n_first;
        r_rd_addr   <= n_rd_addr;
        r_rd_next   <= n_rd_next;
        r_end       <= n_end;
        r_res_found <= n_res_found;
        r_res_page  <= n_res_page;
        r_res_full  <= n_res_full;
        r_out_found <= n_out_found;
        r_out_page  <= n_out_page;
        r_out_full  <= n_out_full;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.victim_found = r_out_found;
    assign o_rsp.victim_page  = r_out_page;
    assign o_rsp.list_full    = r_out_full;

    `SCPV_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(NUM_FRAMES), "entry count above capacity")
    `SCPV_ASSERT_ALWAYS(a_marks_live, i_clk, i_rst_n, (r_marks & ~s_live) == '0, "mark set on empty slot")
    `SCPV_ASSERT_IMPL(a_found_xor_full, i_clk, i_rst_n, o_rsp.valid, !(o_rsp.victim_found && o_rsp.list_full), "victim and full flags together")
    `SCPV_ASSERT_IMPL(a_page_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.victim_found, o_rsp.victim_page == '0, "page set without victim")

endmodule

### rtl/scpv_page_ram.sv
module scpv_page_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
